### sv/stepper_trapezoid_ramp_core_defines.svh
// ----------------------------------------------------------------------------
// stepper ramp assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef STEPPER_TRAPEZOID_RAMP_CORE_DEFINES_SVH
`define STEPPER_TRAPEZOID_RAMP_CORE_DEFINES_SVH

// implication checked each clock outside reset
`define STR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define STR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/str_pkg.sv
// ----------------------------------------------------------------------------
// stepper ramp package
// shared types and constants for the move planner
// ----------------------------------------------------------------------------
`default_nettype none
package str_pkg;

   localparam int unsigned MEDIUM_MIN  = 1000;
   localparam int unsigned EDGE_PULSES = 200;
   localparam int unsigned FAST_CUT    = 7500;
   localparam int unsigned SHORT_CUT   = 5000;

   localparam logic [2:0] CSR_TIMER_CLOCK = 3'd0;
   localparam logic [2:0] CSR_START_FREQ  = 3'd1;
   localparam logic [2:0] CSR_FREQ_STEP   = 3'd2;
   localparam logic [2:0] CSR_MAX_FREQ    = 3'd3;
   localparam logic [2:0] CSR_RAMP_MS     = 3'd4;
   localparam logic [2:0] CSR_RAMP_MIN    = 3'd5;
   localparam logic [2:0] CSR_SLOW_PERIOD = 3'd6;

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_FEED  = 2'd1;
   localparam logic [1:0] FUNC_LIMIT = 2'd2;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_RAMP   = 2'd1;
   localparam logic [1:0] MODE_MEDIUM = 2'd2;
   localparam logic [1:0] MODE_SHORT  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_DIVIDE,
      ST_LENGTH,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   // divider control
   typedef struct packed {
      logic        start;
      logic [23:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic [15:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

### sv/str_divider.sv
// ----------------------------------------------------------------------------
// stepper ramp divider
// restoring divider, one quotient bit per cycle, saturated to 16 bits
// ----------------------------------------------------------------------------
`default_nettype none
module str_divider (
   input  wire                   clock,
   input  wire                   reset,
   input  str_pkg::div_req_type  req,
   output str_pkg::div_rsp_type  rsp
);

   logic [4:0]  cnt_ff, cnt_in;
   logic [23:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic        busy_ff, busy_in;
   logic        zero_ff, zero_in;
   logic [16:0] trial;

   always_comb begin
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      trial   = {rem_ff[15:0], quo_ff[23]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = 5'd24;
         busy_in = 1'b1;
         zero_in = (req.divisor == 16'd0);
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[22:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      zero_ff <= zero_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.quotient = (zero_ff || quo_ff[23:16] != 8'd0) ? 16'hFFFF : quo_ff[15:0];

endmodule
`default_nettype wire

### sv/stepper_trapezoid_ramp_core.sv
// ----------------------------------------------------------------------------
// stepper trapezoid ramp core
// plans a stepper move: ramp levels, periods, completion and position
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  req_    | in  | tvalid/tready   | func, target_pulses, direction
//  rsp_    | out | tvalid/tready   | period, running, dir_out, done_res,
//          |     |                 | refused, position
//  csr_    | in  | wr_en           | index, 24-bit data
//
// each item passes ST_LEVEL, ST_FINISH and ST_OUTPUT; when a ramp level changes,
// ST_DIVIDE and ST_LENGTH come between, the shared restoring divider working out
// timer_clock / freq; a ramp start sets level 0 and then runs the rule pass again,
// which may step up and divide once more; the result waits in an output register;
// the next item is taken the cycle after the result is accepted, never while it is held
// synchronous active-high reset clears the move state and loads register defaults
`default_nettype none
module stepper_trapezoid_ramp_core #(
   parameter int COUNT_BITS = 24
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // func[1:0], target_pulses[25:2], direction[26]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,   // period[15:0], running, dir_out, done_res,
                                    // refused, position[51:20], zero fill
   input  wire         csr_wr_en,
   input  wire  [2:0]  csr_index,
   input  wire  [23:0] csr_data
);

   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   // ceil(2^36 / 1000): floor(x / 1000) = (x * RECIP_1000) >> 36 for x < 2^26
   localparam logic [26:0] RECIP_1000 = 27'd68719477;

   // configuration
   logic [23:0] timer_clock_ff, ramp_min_ff;
   logic [15:0] start_freq_ff, freq_step_ff, max_freq_ff, slow_period_ff;
   logic [9:0]  ramp_ms_ff;

   // move state
   logic                  active_ff, active_in;
   logic [1:0]            mode_ff, mode_in;
   logic                  decel_ff, decel_in;
   logic [15:0]           level_ff, level_in;
   logic [15:0]           freq_ff, freq_in;
   logic [COUNT_BITS-1:0] thr_ff, thr_in;
   logic [COUNT_BITS-1:0] sent_ff, sent_in;
   logic [COUNT_BITS-1:0] goal_ff, goal_in;
   logic                  dir_ff, dir_in;
   logic [1:0]            stage_ff, stage_in;
   logic                  limit_ff, limit_in;
   logic [15:0]           per_ff, per_in;
   logic [31:0]           pos_ff, pos_in;
   logic                  done_ff, done_in;
   logic                  refused_ff, refused_in;
   logic                  eval_ff, eval_in;   // run completion check after level

   str_pkg::state_type state_ff, state_in;
   logic [55:0]        out_ff, out_in;
   logic               ovalid_ff, ovalid_in;
   logic [25:0]        len_ff, len_in;       // ramp_ms * freq product

   str_pkg::div_req_type dreq;
   str_pkg::div_rsp_type drsp;

   logic [1:0]            func;
   logic [COUNT_BITS-1:0] target;
   logic                  up;
   logic [COUNT_BITS-1:0] dpoint;
   logic [23:0]           half_min;
   logic [15:0]           new_level;
   logic                  do_level;
   logic [52:0]           len_prod;
   logic [16:0]           new_len;
   logic [COUNT_BITS:0]   thr_sum;
   logic [COUNT_BITS:0]   sent_sum;
   logic [COUNT_BITS-1:0] edge_end;
   logic                  complete;

   str_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign func   = req_tdata[1:0];
   assign up     = req_tdata[26];
   assign target = (COUNT_BITS >= 24) ? COUNT_BITS'(req_tdata[25:2])
                 : ((req_tdata[25:2] > 24'(CMAX)) ? CMAX : COUNT_BITS'(req_tdata[25:2]));
   assign half_min = {1'b0, ramp_min_ff[23:1]};
   assign dpoint = (goal_ff > COUNT_BITS'(half_min) || COUNT_BITS < 24 && half_min > 24'(CMAX))
                 ? ((32'(goal_ff) > 32'(half_min)) ? goal_ff - COUNT_BITS'(half_min) : '0)
                 : '0;
   // pulses per level: ramp_ms * freq / 1000 by reciprocal multiply
   assign len_prod = {27'd0, len_ff} * {26'd0, RECIP_1000};
   assign new_len  = len_prod[52:36];
   assign thr_sum  = {1'b0, thr_ff} + (COUNT_BITS+1)'(new_len);
   assign sent_sum = {1'b0, sent_ff} + (COUNT_BITS+1)'(2);
   assign edge_end = (32'(goal_ff) > 32'(str_pkg::EDGE_PULSES))
                   ? goal_ff - COUNT_BITS'(str_pkg::EDGE_PULSES) : '0;
   assign complete = (sent_ff >= goal_ff);

   assign req_tready = (state_ff == str_pkg::ST_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         str_pkg::ST_IDLE:   if (req_tvalid && req_tready) state_in = str_pkg::ST_LEVEL;
         str_pkg::ST_LEVEL:  state_in = do_level ? str_pkg::ST_DIVIDE : str_pkg::ST_FINISH;
         str_pkg::ST_DIVIDE: if (!drsp.busy && !dreq.start) state_in = str_pkg::ST_LENGTH;
         // ramp start needs a second rule pass after level 0 is set
         str_pkg::ST_LENGTH: state_in = (stage_ff == 2'd3) ? str_pkg::ST_LEVEL
                                                            : str_pkg::ST_FINISH;
         str_pkg::ST_FINISH: state_in = str_pkg::ST_OUTPUT;
         str_pkg::ST_OUTPUT: state_in = str_pkg::ST_IDLE;
         default:            state_in = str_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      active_in = active_ff; mode_in = mode_ff; decel_in = decel_ff;
      level_in = level_ff; freq_in = freq_ff; thr_in = thr_ff; sent_in = sent_ff;
      goal_in = goal_ff; dir_in = dir_ff; stage_in = stage_ff; limit_in = limit_ff;
      per_in = per_ff; pos_in = pos_ff; done_in = done_ff; refused_in = refused_ff;
      eval_in = eval_ff; out_in = out_ff; ovalid_in = ovalid_ff; len_in = len_ff;
      dreq = '0;
      do_level = 1'b0;
      new_level = level_ff;
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;
      case (state_ff)
         str_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               done_in = 1'b0; refused_in = 1'b0; eval_in = 1'b0;
               if (func == str_pkg::FUNC_START && !active_ff) begin
                  if (!up && limit_ff) begin
                     refused_in = 1'b1;
                  end else begin
                     if (up) limit_in = 1'b0;
                     dir_in = up; goal_in = target; sent_in = '0; decel_in = 1'b0;
                     level_in = '0; stage_in = '0; active_in = 1'b1; eval_in = 1'b1;
                     if (32'(target) >= 32'(ramp_min_ff)) begin
                        mode_in  = str_pkg::MODE_RAMP;
                        thr_in   = '0;
                        stage_in = 2'd3;  // level 0 still to be set
                     end else if (32'(target) >= str_pkg::MEDIUM_MIN) begin
                        mode_in = str_pkg::MODE_MEDIUM;
                        per_in  = slow_period_ff;
                     end else begin
                        mode_in = str_pkg::MODE_SHORT;
                        per_in  = (slow_period_ff > 16'(str_pkg::SHORT_CUT))
                                ? slow_period_ff - 16'(str_pkg::SHORT_CUT) : '0;
                     end
                  end
               end else if (func == str_pkg::FUNC_FEED && active_ff) begin
                  sent_in = sent_sum[COUNT_BITS] ? CMAX : sent_sum[COUNT_BITS-1:0];
                  eval_in = 1'b1;
               end else if (func == str_pkg::FUNC_LIMIT) begin
                  limit_in = 1'b1; active_in = 1'b0; mode_in = str_pkg::MODE_IDLE;
               end
            end
         end
         str_pkg::ST_LEVEL: begin
            if (eval_ff && mode_ff == str_pkg::MODE_RAMP) begin
               if (stage_ff == 2'd3) begin
                  // fresh ramp start: set level 0 first
                  do_level = 1'b1; new_level = 16'd0;
               end else begin
                  if (!decel_ff && sent_ff >= dpoint) begin
                     decel_in = 1'b1; thr_in = sent_ff;
                  end
                  if (sent_ff >= thr_in && freq_ff < max_freq_ff && !decel_in) begin
                     if (level_ff != 16'hFFFF) begin
                        do_level = 1'b1; new_level = level_ff + 16'd1;
                     end
                  end else if (sent_ff >= dpoint && freq_ff > start_freq_ff
                               && sent_ff >= thr_in && decel_in && level_ff != 16'd0) begin
                     do_level = 1'b1; new_level = level_ff - 16'd1;
                  end
               end
               if (do_level) begin
                  level_in = new_level;
                  freq_in  = (33'(start_freq_ff) + 33'(new_level) * 33'(freq_step_ff)
                              > 33'd65535) ? 16'hFFFF : 16'(start_freq_ff + new_level
                              * freq_step_ff);
                  dreq.start    = 1'b1;
                  dreq.dividend = timer_clock_ff;
                  dreq.divisor  = freq_in;
               end
            end
         end
         str_pkg::ST_DIVIDE: begin
            len_in = 26'(ramp_ms_ff) * 26'(freq_ff);
            if (!drsp.busy) per_in = drsp.quotient;
         end
         str_pkg::ST_LENGTH: begin
            thr_in = thr_sum[COUNT_BITS] ? CMAX : thr_sum[COUNT_BITS-1:0];
            // start-of-move pass continues with the normal rule pass
            if (stage_ff == 2'd3) stage_in = 2'd0;
         end
         str_pkg::ST_FINISH: begin
            if (eval_ff && mode_ff != str_pkg::MODE_IDLE) begin
               if (stage_ff == 2'd3) begin
                  stage_in = 2'd0;
               end
               if (mode_ff == str_pkg::MODE_MEDIUM) begin
                  if (32'(sent_ff) >= str_pkg::EDGE_PULSES && stage_ff == 2'd0) begin
                     per_in   = (slow_period_ff > 16'(str_pkg::FAST_CUT))
                              ? slow_period_ff - 16'(str_pkg::FAST_CUT) : '0;
                     stage_in = 2'd1;
                  end
                  if (sent_ff >= edge_end && stage_in == 2'd1) begin
                     per_in = slow_period_ff; stage_in = 2'd2;
                  end
               end
               if ((mode_ff != str_pkg::MODE_MEDIUM || stage_in == 2'd2) && complete) begin
                  active_in = 1'b0; mode_in = str_pkg::MODE_IDLE; done_in = 1'b1;
                  pos_in = dir_ff ? pos_ff + 32'(sent_ff) : pos_ff - 32'(sent_ff);
               end
            end
         end
         str_pkg::ST_OUTPUT: begin
            out_in    = {4'd0, pos_ff, refused_ff, done_ff, dir_ff, active_ff, per_ff};
            ovalid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_clock_ff <= 24'd1000000; start_freq_ff <= 16'd500;
         freq_step_ff <= 16'd100; max_freq_ff <= 16'd5000; ramp_ms_ff <= 10'd20;
         ramp_min_ff <= 24'd4000; slow_period_ff <= 16'd20000;
         state_ff <= str_pkg::ST_IDLE; ovalid_ff <= 1'b0;
         active_ff <= 1'b0; mode_ff <= str_pkg::MODE_IDLE; decel_ff <= 1'b0;
         level_ff <= '0; freq_ff <= '0; thr_ff <= '0; sent_ff <= '0; goal_ff <= '0;
         dir_ff <= 1'b1; stage_ff <= '0; limit_ff <= 1'b0; per_ff <= '0; pos_ff <= '0;
         done_ff <= 1'b0; refused_ff <= 1'b0; eval_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               str_pkg::CSR_TIMER_CLOCK: timer_clock_ff <= csr_data;
               str_pkg::CSR_START_FREQ:  start_freq_ff  <= csr_data[15:0];
               str_pkg::CSR_FREQ_STEP:   freq_step_ff   <= csr_data[15:0];
               str_pkg::CSR_MAX_FREQ:    max_freq_ff    <= csr_data[15:0];
               str_pkg::CSR_RAMP_MS:     ramp_ms_ff     <= csr_data[9:0];
               str_pkg::CSR_RAMP_MIN:    ramp_min_ff    <= csr_data;
               str_pkg::CSR_SLOW_PERIOD: slow_period_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         state_ff <= state_in; ovalid_ff <= ovalid_in;
         active_ff <= active_in; mode_ff <= mode_in; decel_ff <= decel_in;
         level_ff <= level_in; freq_ff <= freq_in; thr_ff <= thr_in; sent_ff <= sent_in;
         goal_ff <= goal_in; dir_ff <= dir_in; stage_ff <= stage_in; limit_ff <= limit_in;
         per_ff <= per_in; pos_ff <= pos_in; done_ff <= done_in; refused_ff <= refused_in;
         eval_ff <= eval_in;
      end
      out_ff <= out_in;
      len_ff <= len_in;
   end

endmodule
`default_nettype wire

### sv/str_checker.sv
// ----------------------------------------------------------------------------
// stepper ramp checker
// port-level properties of the move planner
// ----------------------------------------------------------------------------
`default_nettype none
`include "stepper_trapezoid_ramp_core_defines.svh"
module str_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [31:0] req_tdata,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [55:0] rsp_tdata
);

   `STR_ASSERT_IMPL(a_one_side, clock, reset, rsp_tvalid, !req_tready, "ready while result held")
   `STR_ASSERT_NEXT(a_busy_after, clock, reset, req_tvalid && req_tready, !req_tready, "ready after accept")
   `STR_ASSERT_IMPL(a_done_idle, clock, reset, rsp_tvalid && rsp_tdata[18], !rsp_tdata[16], "done while running")
   `STR_ASSERT_IMPL(a_flags, clock, reset, rsp_tvalid, !(rsp_tdata[18] && rsp_tdata[19]), "done and refused")

endmodule

bind stepper_trapezoid_ramp_core str_checker u_str_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// stepper trapezoid ramp core testbench
// drives start, pulse-feedback, limit and unused-code items through the request stream,
// predicts responses with a cycle-free model of the move planner or the directed
// plan's typed rows, and compares them field by field, over several register sets
// ----------------------------------------------------------------------------
`default_nettype none
module tb;

   // response fields, packed to match rsp_tdata[51:0]
   typedef struct packed {
      logic [31:0] position;
      logic        refused;
      logic        done_res;
      logic        dir_out;
      logic        running;
      logic [15:0] period;
   } move_status_type;

   // one row of the directed plan
   typedef struct {
      logic [1:0]  func;
      int unsigned target;
      bit          dir;
      bit          typed;      // expected status typed in below
      int unsigned period;
      bit          running;
      bit          dir_out;
      bit          done_res;
      bit          refused;
      int unsigned position;
   } plan_row_type;

   localparam int unsigned COUNT_MAX   = 32'h00FF_FFFF;
   localparam int          SETTLE      = 40;     // cycles the block may still be busy
   localparam int          STALL_LIMIT = 4000;   // cycles without any accepted item
   localparam int          LONG_HOLD   = 300;    // receiver hold-off to fill the block
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;   // func code with no meaning

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;

   stepper_trapezoid_ramp_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 20 time unit period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // planner prediction: registers and move state
   // ------------------------------------------------------------------------
   int unsigned reg_val [7];

   bit          mv_active, mv_decel, mv_dir, mv_limit;
   logic [1:0]  mv_mode;
   int unsigned mv_level, mv_freq, mv_thresh, mv_sent, mv_goal, mv_stage;
   logic [15:0] mv_period;
   logic [31:0] mv_pos;

   move_status_type status_q [$];   // statuses still to come out of the block
   int              mismatches;
   int              rsp_count;
   int              idle_cycles;
   bit              tx_burst, rx_burst;

   function automatic int unsigned floor_sub(int unsigned a, int unsigned b);
      return (a > b) ? a - b : 0;
   endfunction

   // timer_clock / freq, saturated to 16 bits, zero freq gives the top value
   function automatic logic [15:0] ticks_for(int unsigned f);
      int unsigned q;
      if (f == 0) return 16'hFFFF;
      q = reg_val[str_pkg::CSR_TIMER_CLOCK] / f;
      return (q > 65535) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic void enter_level(int unsigned level);
      longint unsigned f, len, th;
      mv_level = level;
      f = longint'(reg_val[str_pkg::CSR_START_FREQ])
        + longint'(level) * reg_val[str_pkg::CSR_FREQ_STEP];
      mv_freq = (f > 65535) ? 65535 : int'(f);
      mv_period = ticks_for(mv_freq);
      // pulses spent at this level
      len = (longint'(reg_val[str_pkg::CSR_RAMP_MS]) * mv_freq) / 1000;
      th = longint'(mv_thresh) + len;
      mv_thresh = (th > COUNT_MAX) ? COUNT_MAX : int'(th);
   endfunction

   // move rules, run on a start and on each feedback; 1 when the move ends
   function automatic bit advance_move();
      int unsigned dpoint;
      if (mv_mode == str_pkg::MODE_RAMP) begin
         dpoint = floor_sub(mv_goal, reg_val[str_pkg::CSR_RAMP_MIN] / 2);
         if (!mv_decel && mv_sent >= dpoint) begin
            mv_decel  = 1'b1;
            mv_thresh = mv_sent;
         end
         if (mv_sent >= mv_thresh && mv_freq < reg_val[str_pkg::CSR_MAX_FREQ] && !mv_decel)
         begin
            if (mv_level < 65535) enter_level(mv_level + 1);
         end else if (mv_sent >= dpoint && mv_freq > reg_val[str_pkg::CSR_START_FREQ]
                      && mv_sent >= mv_thresh && mv_decel && mv_level > 0) begin
            enter_level(mv_level - 1);
         end
      end else if (mv_mode == str_pkg::MODE_MEDIUM) begin
         // slow, fast, slow
         if (mv_sent >= str_pkg::EDGE_PULSES && mv_stage == 0) begin
            mv_period = 16'(floor_sub(reg_val[str_pkg::CSR_SLOW_PERIOD], str_pkg::FAST_CUT));
            mv_stage  = 1;
         end
         if (mv_sent >= floor_sub(mv_goal, str_pkg::EDGE_PULSES) && mv_stage == 1) begin
            mv_period = 16'(reg_val[str_pkg::CSR_SLOW_PERIOD]);
            mv_stage  = 2;
         end
         if (mv_stage != 2) return 1'b0;
      end
      if (mv_sent >= mv_goal) begin
         mv_active = 1'b0;
         mv_mode   = str_pkg::MODE_IDLE;
         if (mv_dir) mv_pos = mv_pos + mv_sent;
         else mv_pos = mv_pos - mv_sent;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic move_status_type plan_move(logic [1:0] f, int unsigned tgt, bit up);
      move_status_type s;
      bit done, refused;
      done    = 1'b0;
      refused = 1'b0;
      tgt     = tgt & COUNT_MAX;
      if (f == str_pkg::FUNC_START && !mv_active) begin
         if (!up && mv_limit) begin
            refused = 1'b1;
         end else begin
            if (up) mv_limit = 1'b0;
            mv_dir    = up;
            mv_goal   = tgt;
            mv_sent   = 0;
            mv_decel  = 1'b0;
            mv_level  = 0;
            mv_stage  = 0;
            mv_active = 1'b1;
            if (tgt >= reg_val[str_pkg::CSR_RAMP_MIN]) begin
               mv_mode   = str_pkg::MODE_RAMP;
               mv_thresh = 0;
               enter_level(0);
            end else if (tgt >= str_pkg::MEDIUM_MIN) begin
               mv_mode   = str_pkg::MODE_MEDIUM;
               mv_period = 16'(reg_val[str_pkg::CSR_SLOW_PERIOD]);
            end else begin
               mv_mode   = str_pkg::MODE_SHORT;
               mv_period = 16'(floor_sub(reg_val[str_pkg::CSR_SLOW_PERIOD],
                                         str_pkg::SHORT_CUT));
            end
            done = advance_move();
         end
      end else if (f == str_pkg::FUNC_FEED && mv_active) begin
         // feedback comes in pairs of pulses
         mv_sent = (mv_sent + 2 > COUNT_MAX) ? COUNT_MAX : mv_sent + 2;
         done = advance_move();
      end else if (f == str_pkg::FUNC_LIMIT) begin
         // abort without a position update
         mv_limit  = 1'b1;
         mv_active = 1'b0;
         mv_mode   = str_pkg::MODE_IDLE;
      end
      s.period   = mv_period;
      s.running  = mv_active;
      s.dir_out  = mv_dir;
      s.done_res = done;
      s.refused  = refused;
      s.position = mv_pos;
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic offer_item(logic [1:0] f, int unsigned tgt, bit up, bit typed,
                             move_status_type want);
      int gap;
      move_status_type s;
      if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, up, tgt[23:0], f};
      do @(posedge clock); while (!req_tready);
      s = plan_move(f, tgt, up);
      status_q.push_back(typed ? want : s);
   endtask

   task automatic send(logic [1:0] f, int unsigned tgt, bit up);
      offer_item(f, tgt, up, 1'b0, '0);
   endtask

   // start a move and feed it pulses to its end, with some noise and aborts
   task automatic run_move(int unsigned tgt, bit up, bit may_abort, inout int cnt);
      int r;
      send(str_pkg::FUNC_START, tgt, up);
      cnt++;
      while (mv_active) begin
         r = $urandom_range(0, 99);
         if (r < 2)
            send(FUNC_UNUSED, $urandom_range(0, COUNT_MAX), 1'($urandom_range(0, 1)));
         else if (r < 4)
            send(str_pkg::FUNC_START, $urandom_range(0, COUNT_MAX), 1'($urandom_range(0, 1)));
         else if (may_abort && r < 6)
            send(str_pkg::FUNC_LIMIT, $urandom_range(0, COUNT_MAX), 1'b0);
         else
            send(str_pkg::FUNC_FEED, $urandom_range(0, COUNT_MAX), 1'($urandom_range(0, 1)));
         cnt++;
      end
   endtask

   // stop offering, wait for every status, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (status_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_regs(int unsigned v [7]);
      for (int i = 0; i < 7; i++) begin
         csr_wr_en  <= 1'b1;
         csr_index  <= i[2:0];
         csr_data   <= v[i][23:0];
         reg_val[i] = v[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   initial begin
      int  stall;
      bit  held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 15);
         // one long hold-off so the block backs up into the request side
         if (!held && rsp_count >= 150) begin
            stall = LONG_HOLD;
            held  = 1'b1;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic report(string what, move_status_type want, move_status_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch %s: expected per=%0d run=%0b dir=%0b done=%0b ref=%0b pos=%0d",
                  what, want.period, want.running, want.dir_out, want.done_res,
                  want.refused, $signed(want.position));
         $display("   got per=%0d run=%0b dir=%0b done=%0b ref=%0b pos=%0d",
                  got.period, got.running, got.dir_out, got.done_res,
                  got.refused, $signed(got.position));
      end
   endtask

   always @(posedge clock) begin
      move_status_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[51:0];
         rsp_count <= rsp_count + 1;
         if (status_q.size() == 0) begin
            report("unexpected item", '0, got);
         end else begin
            want = status_q.pop_front();
            if (got.period !== want.period) report("period", want, got);
            if (got.running !== want.running) report("running", want, got);
            if (got.dir_out !== want.dir_out) report("dir_out", want, got);
            if (got.done_res !== want.done_res) report("done_res", want, got);
            if (got.refused !== want.refused) report("refused", want, got);
            if (got.position !== want.position) report("position", want, got);
         end
      end
   end

   // watchdog: cycles in which neither side accepts an item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      plan_row_type    plan [20];
      move_status_type want;
      int unsigned     regs [7];
      int              cnt, budget, r, n;
      bit              up;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      mismatches = 0;
      rsp_count  = 0;
      idle_cycles = 0;
      tx_burst   = 1'b0;
      rx_burst   = 1'b0;

      // register defaults and move state after reset
      reg_val   = '{1000000, 500, 100, 5000, 20, 4000, 20000};
      mv_active = 1'b0; mv_decel = 1'b0; mv_dir = 1'b1; mv_limit = 1'b0;
      mv_mode   = str_pkg::MODE_IDLE; mv_level = 0; mv_freq = 0; mv_thresh = 0;
      mv_sent   = 0; mv_goal = 0; mv_stage = 0; mv_period = '0; mv_pos = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed plan on the reset registers:
      // func, target, dir, typed, period, running, dir_out, done, refused, position
      plan = '{
         '{str_pkg::FUNC_FEED,  0,        1'b1, 1'b1, 0,     0, 1, 0, 0, 0},  // idle feed
         '{FUNC_UNUSED,         COUNT_MAX,1'b1, 1'b1, 0,     0, 1, 0, 0, 0},  // unused func
         '{str_pkg::FUNC_START, 0,        1'b1, 1'b1, 15000, 0, 1, 1, 0, 0},  // zero length
         '{str_pkg::FUNC_START, 4,        1'b1, 1'b1, 15000, 1, 1, 0, 0, 0},  // short up
         '{str_pkg::FUNC_FEED,  0,        1'b0, 1'b1, 15000, 1, 1, 0, 0, 0},
         '{str_pkg::FUNC_FEED,  0,        1'b0, 1'b1, 15000, 0, 1, 1, 0, 4},
         '{str_pkg::FUNC_START, 3,        1'b0, 1'b1, 15000, 1, 0, 0, 0, 4},  // short down
         '{str_pkg::FUNC_FEED,  0,        1'b0, 1'b0, 0,     0, 0, 0, 0, 0},
         '{str_pkg::FUNC_FEED,  0,        1'b0, 1'b1, 15000, 0, 0, 1, 0, 0},  // overshoot
         '{str_pkg::FUNC_LIMIT, 0,        1'b0, 1'b1, 15000, 0, 0, 0, 0, 0},
         '{str_pkg::FUNC_START, 5,        1'b0, 1'b1, 15000, 0, 0, 0, 1, 0},  // refused
         '{str_pkg::FUNC_START, COUNT_MAX,1'b1, 1'b1, 2000,  1, 1, 0, 0, 0},  // long ramp
         '{str_pkg::FUNC_FEED,  0,        1'b1, 1'b0, 0,     0, 0, 0, 0, 0},
         '{str_pkg::FUNC_START, 7,        1'b0, 1'b1, 2000,  1, 1, 0, 0, 0},  // while active
         '{str_pkg::FUNC_LIMIT, 0,        1'b1, 1'b1, 2000,  0, 1, 0, 0, 0},  // abort
         '{str_pkg::FUNC_START, 1500,     1'b0, 1'b1, 2000,  0, 1, 0, 1, 0},
         '{str_pkg::FUNC_START, 1000,     1'b1, 1'b1, 20000, 1, 1, 0, 0, 0},  // medium
         '{str_pkg::FUNC_LIMIT, 0,        1'b0, 1'b0, 0,     0, 0, 0, 0, 0},
         '{str_pkg::FUNC_START, 999,      1'b1, 1'b1, 15000, 1, 1, 0, 0, 0},  // longest short
         '{str_pkg::FUNC_LIMIT, 0,        1'b1, 1'b1, 15000, 0, 1, 0, 0, 0}
      };
      foreach (plan[i]) begin
         want = {plan[i].position, plan[i].refused, plan[i].done_res, plan[i].dir_out,
                 plan[i].running, plan[i].period[15:0]};
         offer_item(plan[i].func, plan[i].target, plan[i].dir, plan[i].typed, want);
      end
      drain();

      // random phases, each under its own register set
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            // quick ramp levels
            0: regs = '{1000000, 500, 100, 5000, 1, 1002, 20000};
            // upper extremes, frequency saturates
            1: regs = '{COUNT_MAX, 1, 65535, 65535, 1000, 1002, 7501};
            // lower extremes, medium and short moves, a ramp only for a full-scale target
            2: regs = '{1, 65535, 1, 1, 1, COUNT_MAX, 65535};
            default: regs = '{$urandom_range(1, COUNT_MAX), $urandom_range(1, 2000),
                               $urandom_range(1, 500), $urandom_range(1, 8000),
                               $urandom_range(1, 1000), $urandom_range(1002, 1100),
                               $urandom_range(7501, 65535)};
         endcase
         load_regs(regs);
         cnt    = 0;
         budget = (ph < 3) ? 1 : 40;
         if (mv_active) begin
            send(str_pkg::FUNC_LIMIT, 0, 1'b0);
            cnt++;
         end
         // one full long move in each of the first three phases keeps the ramp or medium profile busy
         if (ph < 3) run_move($urandom_range(1002, 1040), 1'b1, 1'b0, cnt);
         while (cnt < budget) begin
            r  = $urandom_range(0, 99);
            up = 1'($urandom_range(0, 1));
            if (r < 80) begin
               run_move($urandom_range(0, 60), up, 1'b1, cnt);
            end else if (r < 90) begin
               // full-width target, a few pulses, then a limit abort
               send(str_pkg::FUNC_START, $urandom_range(0, COUNT_MAX), up);
               n = $urandom_range(0, 5);
               repeat (n) send(str_pkg::FUNC_FEED, 0, 1'b0);
               send(str_pkg::FUNC_LIMIT, $urandom_range(0, COUNT_MAX), up);
               cnt += n + 2;
            end else begin
               send(2'($urandom_range(1, 3)), $urandom_range(0, COUNT_MAX), up);
               cnt++;
            end
         end
         drain();
      end

      if (mismatches == 0 && status_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
